>>> sv/chha_pkg.sv
`default_nettype none
package chha_pkg;

    localparam int DEF_MAX_HANDLES = 64;
    localparam int ADDR_W = 21;
    localparam int CNT_W = 7;
    localparam int HID_W = 6;

    localparam logic [ADDR_W-1:0] HDR_BYTES = 21'd8;
    localparam logic [ADDR_W-1:0] RESERVED_BYTES = 21'd16;
    localparam logic [ADDR_W-1:0] HEAP_RESET = 21'h100000;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NOHANDLE = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    typedef enum logic [1:0] {
        OUT_RESP = 2'd0,
        OUT_MOVE = 2'd1,
        OUT_FIN  = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0] offs;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] req;
    } hent_t;

    typedef struct packed {
        logic       take_item;
        logic       grant;
        logic       hm_rd_hid;
        logic       free_apply;
        logic       srch_step;
        logic       set_found;
        logic       i_inc;
        logic       move_apply;
        logic       out_load;
        out_kind_t  out_kind;
        logic [1:0] resp_status;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic nospace;
        logic nohandle;
        logic badfree;
        logic out_free;
        logic scan_end;
        logic ao_match;
        logic found;
        logic srch_done;
    } sts_t;

endpackage
`default_nettype wire

>>> sv/chha_ctrl.sv
`default_nettype none
module chha_ctrl import chha_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHK   = 9'b000000010,
        S_RESP  = 9'b000000100,
        S_HSRCH = 9'b000001000,
        S_FRD   = 9'b000010000,
        S_SRD   = 9'b000100000,
        S_AOW   = 9'b001000000,
        S_HRD   = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg <= ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg <= st_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        cmd.out_kind = OUT_RESP;
        state_next = state_reg;
        st_next = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (!sts.is_free) begin
                    priority if (sts.nospace) begin
                        st_next = ST_NOSPACE;
                    end else if (sts.nohandle) begin
                        st_next = ST_NOHANDLE;
                    end else begin
                        cmd.grant = 1'b1;
                        st_next = ST_OK;
                    end
                    state_next = S_RESP;
                end else if (sts.badfree) begin
                    st_next = ST_BADFREE;
                    state_next = S_RESP;
                end else begin
                    cmd.hm_rd_hid = 1'b1;
                    state_next = S_FRD;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_RESP;
                    cmd.resp_status = st_reg;
                    state_next = (st_reg == ST_OK) ? S_HSRCH : S_IDLE;
                end
            end
            S_HSRCH: begin
                cmd.srch_step = 1'b1;
                if (sts.srch_done) begin
                    state_next = S_IDLE;
                end
            end
            S_FRD: begin
                cmd.free_apply = 1'b1;
                state_next = S_SRD;
            end
            S_SRD: begin
                state_next = sts.scan_end ? S_FIN : S_AOW;
            end
            S_AOW: begin
                if (sts.found) begin
                    state_next = S_HRD;
                end else begin
                    cmd.set_found = sts.ao_match;
                    cmd.i_inc = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_HRD: begin
                if (sts.out_free) begin
                    cmd.move_apply = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_MOVE;
                    state_next = S_SRD;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_FIN;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/chha_dp.sv
`default_nettype none
module chha_dp import chha_pkg::*; #(
    parameter int MAX_HANDLES = DEF_MAX_HANDLES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic              s_action,
    input  wire logic [ADDR_W-1:0] s_request_bytes,
    input  wire logic [HID_W-1:0]  s_handle_id,
    input  wire logic              s_handle_null,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_heap_bytes,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [HID_W-1:0]       m_result_handle,
    output logic [ADDR_W-1:0]      m_payload_offset,
    output logic [ADDR_W-1:0]      m_move_source,
    output logic [ADDR_W-1:0]      m_move_target,
    output logic [ADDR_W-1:0]      m_move_length,
    output logic [ADDR_W-1:0]      m_free_pointer,
    output logic [CNT_W-1:0]       m_live_blocks,
    output logic [ADDR_W-1:0]      m_raw_in_use,
    output logic [ADDR_W-1:0]      m_padded_in_use,
    output logic                   m_last
);

    localparam int HIW = $clog2(MAX_HANDLES);
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_HANDLES);

    hent_t             hm_mem [MAX_HANDLES];
    logic [HIW-1:0]    ao_mem [MAX_HANDLES];
    hent_t             hm_q;
    logic [HIW-1:0]    ao_q;

    logic [ADDR_W-1:0] heap_reg;
    logic              act_reg;
    logic [ADDR_W-1:0] req_reg;
    logic [HID_W-1:0]  hid_reg;
    logic              hnull_reg;
    logic [ADDR_W-1:0] free_reg, raw_reg, pad_reg;
    logic [CNT_W-1:0]  cnt_reg, lfh_reg, srch_reg, i_reg, old_reg;
    logic [MAX_HANDLES-1:0] used_reg;
    logic              found_reg;
    logic [HIW-1:0]    gh_reg;
    logic [ADDR_W-1:0] gpay_reg, cur_reg;

    logic              mv_reg;
    logic [1:0]        st_reg;
    logic [HID_W-1:0]  hd_reg;
    logic [ADDR_W-1:0] pay_reg, src_reg, dst_reg, len_reg;
    logic              last_reg;

    logic [1:0]        st_next;
    logic [HID_W-1:0]  hd_next;
    logic [ADDR_W-1:0] pay_next, src_next, dst_next, len_next;
    logic              last_next;

    logic [ADDR_W:0]   rnd, size22;
    logic [HIW-1:0]    hm_raddr, hm_waddr, ao_waddr, hid_idx;
    hent_t             hm_wdata;
    logic              hm_we, ao_we;
    logic [HIW-1:0]    ao_wdata;

    assign hid_idx = hid_reg[HIW-1:0];
    assign rnd = ({1'b0, req_reg} + (ADDR_W+1)'(7)) & ~(ADDR_W+1)'(7);
    assign size22 = rnd + {1'b0, HDR_BYTES};

    always_comb begin
        sts.is_free = act_reg;
        sts.nospace = (free_reg > heap_reg) || ({1'b0, heap_reg - free_reg} < size22);
        sts.nohandle = (lfh_reg >= MAXC) || (cnt_reg >= MAXC);
        sts.badfree = hnull_reg || ({1'b0, hid_reg} >= MAXC) || !used_reg[hid_idx];
        sts.out_free = !mv_reg || m_ready;
        sts.scan_end = (i_reg >= old_reg);
        sts.ao_match = (ao_q == hid_idx);
        sts.found = found_reg;
        sts.srch_done = (srch_reg >= MAXC) || !used_reg[srch_reg[HIW-1:0]];
    end

    assign hm_raddr = cmd.hm_rd_hid ? hid_idx : ao_q;

    always_comb begin
        hm_we = cmd.grant || cmd.move_apply;
        ao_we = cmd.grant || cmd.move_apply;
        if (cmd.grant) begin
            hm_waddr = lfh_reg[HIW-1:0];
            hm_wdata.offs = free_reg + HDR_BYTES;
            hm_wdata.size = size22[ADDR_W-1:0];
            hm_wdata.req = req_reg;
            ao_waddr = cnt_reg[HIW-1:0];
            ao_wdata = lfh_reg[HIW-1:0];
        end else begin
            hm_waddr = ao_q;
            hm_wdata.offs = cur_reg + HDR_BYTES;
            hm_wdata.size = hm_q.size;
            hm_wdata.req = hm_q.req;
            ao_waddr = HIW'(i_reg - CNT_W'(1));
            ao_wdata = ao_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (hm_we) begin
            hm_mem[hm_waddr] <= hm_wdata;
        end
        if (ao_we) begin
            ao_mem[ao_waddr] <= ao_wdata;
        end
        hm_q <= hm_mem[hm_raddr];
        ao_q <= ao_mem[i_reg[HIW-1:0]];
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_reg <= HEAP_RESET;
            free_reg <= RESERVED_BYTES;
            pad_reg <= RESERVED_BYTES;
            raw_reg <= '0;
            cnt_reg <= '0;
            lfh_reg <= '0;
            used_reg <= '0;
            found_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                heap_reg <= cfg_heap_bytes;
            end
            if (cmd.grant) begin
                used_reg[lfh_reg[HIW-1:0]] <= 1'b1;
                cnt_reg <= cnt_reg + CNT_W'(1);
                raw_reg <= raw_reg + req_reg;
                pad_reg <= pad_reg + size22[ADDR_W-1:0];
                free_reg <= free_reg + size22[ADDR_W-1:0];
            end
            if (cmd.srch_step && sts.srch_done) begin
                lfh_reg <= srch_reg;
            end
            if (cmd.free_apply) begin
                used_reg[hid_idx] <= 1'b0;
                cnt_reg <= cnt_reg - CNT_W'(1);
                raw_reg <= raw_reg - hm_q.req;
                pad_reg <= pad_reg - hm_q.size;
                free_reg <= free_reg - hm_q.size;
                if ({1'b0, hid_reg} < lfh_reg) begin
                    lfh_reg <= {1'b0, hid_reg};
                end
                found_reg <= 1'b0;
            end
            if (cmd.set_found) begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        src_next = '0;
        dst_next = '0;
        len_next = '0;
        pay_next = '0;
        last_next = 1'b1;
        st_next = ST_OK;
        hd_next = hid_reg;
        unique case (cmd.out_kind)
            OUT_RESP: begin
                st_next = cmd.resp_status;
                if (cmd.resp_status == ST_OK) begin
                    hd_next = HID_W'(gh_reg);
                    pay_next = gpay_reg;
                end else if (cmd.resp_status != ST_BADFREE) begin
                    hd_next = '0;
                end
            end
            OUT_MOVE: begin
                hd_next = HID_W'(ao_q);
                pay_next = cur_reg + HDR_BYTES;
                src_next = hm_q.offs - HDR_BYTES;
                dst_next = cur_reg;
                len_next = hm_q.size;
                last_next = 1'b0;
            end
            OUT_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            act_reg <= s_action;
            req_reg <= s_request_bytes;
            hid_reg <= s_handle_id;
            hnull_reg <= s_handle_null;
        end
        if (cmd.grant) begin
            gh_reg <= lfh_reg[HIW-1:0];
            gpay_reg <= free_reg + HDR_BYTES;
            srch_reg <= lfh_reg + CNT_W'(1);
        end else if (cmd.srch_step) begin
            srch_reg <= srch_reg + CNT_W'(1);
        end
        if (cmd.free_apply) begin
            cur_reg <= hm_q.offs - HDR_BYTES;
            old_reg <= cnt_reg;
            i_reg <= '0;
        end else if (cmd.i_inc || cmd.move_apply) begin
            i_reg <= i_reg + CNT_W'(1);
        end
        if (cmd.move_apply) begin
            cur_reg <= cur_reg + hm_q.size;
        end
        if (cmd.out_load) begin
            src_reg <= src_next;
            dst_reg <= dst_next;
            len_reg <= len_next;
            pay_reg <= pay_next;
            last_reg <= last_next;
            st_reg <= st_next;
            hd_reg <= hd_next;
            m_free_pointer <= free_reg;
            m_live_blocks <= cnt_reg;
            m_raw_in_use <= raw_reg;
            m_padded_in_use <= pad_reg;
        end
    end

    assign m_valid = mv_reg;
    assign m_status = st_reg;
    assign m_result_handle = hd_reg;
    assign m_payload_offset = pay_reg;
    assign m_move_source = src_reg;
    assign m_move_target = dst_reg;
    assign m_move_length = len_reg;
    assign m_last = last_reg;

endmodule
`default_nettype wire

>>> sv/compacting_handle_heap_allocator.sv
// Compacting heap allocator with a handle table. An allocation rounds the
// request up to a multiple of 8 bytes, adds an 8-byte header, places the block
// at the free pointer and binds it to the lowest unused handle; it gives one
// result and then searches the handle slots above the grant, up to the first
// unused one, for the next unused handle. A free gives one move result per
// block above the freed one, then a final result; it walks the address-order
// and handle memories from the lowest block. Each result also waits until the
// output register is free. heap_bytes must be written on the cfg channel only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module compacting_handle_heap_allocator import chha_pkg::*; #(
    parameter int MAX_HANDLES = DEF_MAX_HANDLES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_action,
    input  wire logic [ADDR_W-1:0] s_request_bytes,
    input  wire logic [HID_W-1:0]  s_handle_id,
    input  wire logic              s_handle_null,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_heap_bytes,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [HID_W-1:0]       m_result_handle,
    output logic [ADDR_W-1:0]      m_payload_offset,
    output logic [ADDR_W-1:0]      m_move_source,
    output logic [ADDR_W-1:0]      m_move_target,
    output logic [ADDR_W-1:0]      m_move_length,
    output logic [ADDR_W-1:0]      m_free_pointer,
    output logic [CNT_W-1:0]       m_live_blocks,
    output logic [ADDR_W-1:0]      m_raw_in_use,
    output logic [ADDR_W-1:0]      m_padded_in_use,
    output logic                   m_last
);

    cmd_t cmd;
    sts_t sts;

    chha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    chha_dp #(.MAX_HANDLES(MAX_HANDLES)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_action         (s_action),
        .s_request_bytes  (s_request_bytes),
        .s_handle_id      (s_handle_id),
        .s_handle_null    (s_handle_null),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_heap_bytes   (cfg_heap_bytes),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_handle  (m_result_handle),
        .m_payload_offset (m_payload_offset),
        .m_move_source    (m_move_source),
        .m_move_target    (m_move_target),
        .m_move_length    (m_move_length),
        .m_free_pointer   (m_free_pointer),
        .m_live_blocks    (m_live_blocks),
        .m_raw_in_use     (m_raw_in_use),
        .m_padded_in_use  (m_padded_in_use),
        .m_last           (m_last)
    );

endmodule
`default_nettype wire

>>> sv/chha_chk.sv
`default_nettype none
module chha_chk import chha_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [1:0]        m_status,
    input wire logic [HID_W-1:0]  m_result_handle,
    input wire logic [ADDR_W-1:0] m_payload_offset,
    input wire logic [ADDR_W-1:0] m_move_length,
    input wire logic              m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_handle)
            && $stable(m_payload_offset) && $stable(m_last))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    a_last_nomove: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_move_length == '0)
        else $error("final result carries a move");

    a_fail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_last && m_payload_offset == '0)
        else $error("failing result not final");

    a_move_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_move_length >= HDR_BYTES && m_status == ST_OK)
        else $error("bad move result");

endmodule

bind compacting_handle_heap_allocator chha_chk u_chk (.*);
`default_nettype wire

>>> bench/alloc_tb_pkg.sv
`timescale 1ns / 100ps
package alloc_tb_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

endpackage

>>> bench/alloc_checker.sv
`timescale 1ns / 100ps
module alloc_checker import chha_pkg::*; import alloc_tb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic              s_action,
    input  wire logic [ADDR_W-1:0] s_request_bytes,
    input  wire logic [HID_W-1:0]  s_handle_id,
    input  wire logic              s_handle_null,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_heap_bytes,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [1:0]        m_status,
    input  wire logic [HID_W-1:0]  m_result_handle,
    input  wire logic [ADDR_W-1:0] m_payload_offset,
    input  wire logic [ADDR_W-1:0] m_move_source,
    input  wire logic [ADDR_W-1:0] m_move_target,
    input  wire logic [ADDR_W-1:0] m_move_length,
    input  wire logic [ADDR_W-1:0] m_free_pointer,
    input  wire logic [CNT_W-1:0]  m_live_blocks,
    input  wire logic [ADDR_W-1:0] m_raw_in_use,
    input  wire logic [ADDR_W-1:0] m_padded_in_use,
    input  wire logic              m_last,
    output int                     fail_count,
    output int                     pending,
    output logic [63:0]            live_handles
);

    localparam int NHANDLES = DEF_MAX_HANDLES;

    typedef struct packed {
        logic [1:0]        status;
        logic [HID_W-1:0]  handle;
        logic [ADDR_W-1:0] payload;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] free_ptr;
        logic [CNT_W-1:0]  live;
        logic [ADDR_W-1:0] raw;
        logic [ADDR_W-1:0] padded;
        logic              last;
    } alloc_result_t;

    alloc_result_t result_q[$];

    int unsigned blk_payload[NHANDLES];
    int unsigned blk_size[NHANDLES];
    int unsigned blk_pad[NHANDLES];
    bit          blk_used[NHANDLES];
    int unsigned heap_order[NHANDLES];
    int unsigned next_handle;
    int unsigned free_ptr;
    int unsigned nblocks;
    int unsigned raw_total;
    int unsigned padded_total;
    int unsigned heap_limit;

    initial begin
        fail_count = 0;
    end

    always_comb begin
        pending = result_q.size();
        for (int i = 0; i < NHANDLES; i++) live_handles[i] = blk_used[i];
    end

    function automatic void push_result(logic [1:0] st, int unsigned h, int unsigned pay,
                                        int unsigned src, int unsigned dst,
                                        int unsigned len, logic last);
        alloc_result_t r;
        r.status   = st;
        r.handle   = h[HID_W-1:0];
        r.payload  = pay[ADDR_W-1:0];
        r.src      = src[ADDR_W-1:0];
        r.dst      = dst[ADDR_W-1:0];
        r.len      = len[ADDR_W-1:0];
        r.free_ptr = free_ptr[ADDR_W-1:0];
        r.live     = nblocks[CNT_W-1:0];
        r.raw      = raw_total[ADDR_W-1:0];
        r.padded   = padded_total[ADDR_W-1:0];
        r.last     = last;
        result_q.push_back(r);
    endfunction

    function automatic void predict_alloc(int unsigned req);
        int unsigned sz;
        int unsigned h;
        sz = (((req + 7) >> 3) << 3) + 8;
        if (free_ptr > heap_limit || heap_limit - free_ptr < sz) begin
            push_result(ST_NOSPACE, 0, 0, 0, 0, 0, 1'b1);
        end else if (next_handle >= NHANDLES || nblocks >= NHANDLES) begin
            push_result(ST_NOHANDLE, 0, 0, 0, 0, 0, 1'b1);
        end else begin
            h = next_handle;
            blk_payload[h] = free_ptr + 8;
            blk_size[h] = sz;
            blk_pad[h] = sz - 8 - req;
            blk_used[h] = 1'b1;
            heap_order[nblocks] = h;
            nblocks++;
            raw_total += req;
            padded_total += sz;
            free_ptr += sz;
            next_handle = NHANDLES;
            for (int i = h + 1; i < NHANDLES; i++) begin
                if (!blk_used[i]) begin
                    next_handle = i;
                    break;
                end
            end
            push_result(ST_OK, h, blk_payload[h], 0, 0, 0, 1'b1);
        end
    endfunction

    function automatic void predict_free(int unsigned hid, logic hnull);
        int unsigned old_n;
        int unsigned pos;
        int unsigned cur;
        int unsigned sz;
        int unsigned h;
        if (hnull || !blk_used[hid]) begin
            push_result(ST_BADFREE, hid, 0, 0, 0, 0, 1'b1);
            return;
        end
        old_n = nblocks;
        pos = old_n;
        for (int i = 0; i < old_n; i++) begin
            if (heap_order[i] == hid) begin
                pos = i;
                break;
            end
        end
        sz = blk_size[hid];
        cur = blk_payload[hid] - 8;
        nblocks--;
        raw_total -= sz - 8 - blk_pad[hid];
        padded_total -= sz;
        free_ptr -= sz;
        blk_used[hid] = 1'b0;
        if (hid < next_handle) next_handle = hid;
        for (int i = pos + 1; i < old_n; i++) begin
            h = heap_order[i];
            push_result(ST_OK, h, cur + 8, blk_payload[h] - 8, cur, blk_size[h], 1'b0);
            blk_payload[h] = cur + 8;
            heap_order[i - 1] = h;
            cur += blk_size[h];
        end
        push_result(ST_OK, hid, 0, 0, 0, 0, 1'b1);
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        alloc_result_t e;
        if (!aresetn) begin
            result_q.delete();
            for (int i = 0; i < NHANDLES; i++) blk_used[i] = 1'b0;
            next_handle = 0;
            free_ptr = 16;
            nblocks = 0;
            raw_total = 0;
            padded_total = 16;
            heap_limit = HEAP_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    e = result_q.pop_front();
                    check_field("status", e.status, m_status);
                    check_field("result_handle", e.handle, m_result_handle);
                    check_field("payload_offset", e.payload, m_payload_offset);
                    check_field("move_source", e.src, m_move_source);
                    check_field("move_target", e.dst, m_move_target);
                    check_field("move_length", e.len, m_move_length);
                    check_field("free_pointer", e.free_ptr, m_free_pointer);
                    check_field("live_blocks", e.live, m_live_blocks);
                    check_field("raw_in_use", e.raw, m_raw_in_use);
                    check_field("padded_in_use", e.padded, m_padded_in_use);
                    check_field("last", e.last, m_last);
                end
            end
            if (cfg_valid && cfg_ready) heap_limit = cfg_heap_bytes;
            if (s_valid && s_ready) begin
                if (s_action == ACT_ALLOC) predict_alloc(s_request_bytes);
                else predict_free(s_handle_id, s_handle_null);
            end
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top import chha_pkg::*; import alloc_tb_pkg::*;;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_action = ACT_ALLOC;
    logic [ADDR_W-1:0] s_request_bytes = '0;
    logic [HID_W-1:0]  s_handle_id = '0;
    logic              s_handle_null = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_heap_bytes = HEAP_RESET;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_status;
    logic [HID_W-1:0]  m_result_handle;
    logic [ADDR_W-1:0] m_payload_offset;
    logic [ADDR_W-1:0] m_move_source;
    logic [ADDR_W-1:0] m_move_target;
    logic [ADDR_W-1:0] m_move_length;
    logic [ADDR_W-1:0] m_free_pointer;
    logic [CNT_W-1:0]  m_live_blocks;
    logic [ADDR_W-1:0] m_raw_in_use;
    logic [ADDR_W-1:0] m_padded_in_use;
    logic              m_last;

    int          fail_count;
    int          pending;
    logic [63:0] live_handles;
    int          items_sent = 0;
    bit          long_hold_done = 1'b0;

    always #5 aclk = ~aclk;

    compacting_handle_heap_allocator dut (.*);

    alloc_checker checker_i (.*);

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin
        int r;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && items_sent >= 150) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 19);
                if (r < 12) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    if (r < 18) repeat ($urandom_range(1, 3)) @(posedge aclk);
                    else repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    task automatic send_item(logic act, logic [ADDR_W-1:0] req, logic [HID_W-1:0] hid,
                             logic hnull);
        int r;
        r = $urandom_range(0, 19);
        if (r >= 10) begin
            s_valid <= 1'b0;
            if (r < 18) repeat ($urandom_range(1, 3)) @(posedge aclk);
            else repeat ($urandom_range(10, 40)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_request_bytes <= req;
        s_handle_id <= hid;
        s_handle_null <= hnull;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_heap_size(logic [ADDR_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_heap_bytes <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [HID_W-1:0] pick_live();
        int start;
        start = $urandom_range(0, 63);
        for (int i = 0; i < 64; i++) begin
            if (live_handles[(start + i) % 64]) return HID_W'((start + i) % 64);
        end
        return HID_W'(start);
    endfunction

    task automatic random_item(int alloc_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            if ($urandom_range(0, 19) == 0)
                send_item(ACT_ALLOC, ADDR_W'($urandom_range(0, 1048576)),
                          HID_W'($urandom), 1'($urandom));
            else
                send_item(ACT_ALLOC, ADDR_W'($urandom_range(0, 200)),
                          HID_W'($urandom), 1'($urandom));
        end else if (r < 90) begin
            send_item(ACT_FREE, ADDR_W'($urandom), pick_live(), 1'b0);
        end else begin
            send_item(ACT_FREE, ADDR_W'($urandom), HID_W'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] heap_set[5];
        heap_set = '{21'd16, 21'd600, 21'd4096, 21'd0, HEAP_RESET};
        heap_set[3] = ADDR_W'($urandom_range(16, 1048576));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        write_heap_size(HEAP_RESET);

        send_item(ACT_ALLOC, 21'd0, '0, 1'b0);
        send_item(ACT_ALLOC, 21'd1, '0, 1'b0);
        send_item(ACT_ALLOC, 21'd1048576, 6'd63, 1'b1);
        send_item(ACT_ALLOC, 21'd7, '0, 1'b0);
        send_item(ACT_ALLOC, 21'd8, '0, 1'b0);
        send_item(ACT_ALLOC, 21'd9, '0, 1'b0);
        send_item(ACT_FREE, '0, 6'd5, 1'b1);
        send_item(ACT_FREE, '0, 6'd63, 1'b0);
        send_item(ACT_FREE, '0, 6'd2, 1'b1);
        send_item(ACT_FREE, 21'h1FFFFF, 6'd1, 1'b0);
        send_item(ACT_FREE, '0, 6'd0, 1'b0);
        send_item(ACT_FREE, '0, 6'd4, 1'b0);
        send_item(ACT_ALLOC, 21'd1048000, '0, 1'b0);

        // issue small allocations until the heap or the handle table runs out
        for (int i = 0; i < 70; i++)
            send_item(ACT_ALLOC, ADDR_W'($urandom_range(0, 40)), '0, 1'b0);
        for (int i = 0; i < 10; i++) random_item(30);

        foreach (heap_set[k]) begin
            write_heap_size(heap_set[k]);
            for (int i = 0; i < 48; i++) random_item(k == 4 ? 70 : 55);
        end

        drain();
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
